@@ hw/rtl/bddc_pkg.sv @@
// bddc_pkg: shared types and codes for the button debounce duration classifier
// no dependencies; imported by the top level and its checker

package bddc_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DEB  = 2'd1,
		PH_HELD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EV_SHORT = 2'd0,
		EV_LONG  = 2'd1,
		EV_XLONG = 2'd2
	} event_kind_t;

	// register indexes, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG       = 2'd1,
		REG_EXTRA_LONG = 2'd2,
		REG_ACTIVE_LVL = 2'd3
	} reg_index_t;

	localparam int DUR_BITS  = 31;
	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 4;

	localparam logic [DUR_BITS-1:0] DEBOUNCE_RST   = 31'd20;
	localparam logic [DUR_BITS-1:0] LONG_RST       = 31'd1000;
	localparam logic [DUR_BITS-1:0] EXTRA_LONG_RST = 31'd3000;

endpackage

@@ hw/rtl/button_debounce_duration_classifier.sv @@
// button_debounce_duration_classifier: debounce and press duration classifier
// depends on bddc_pkg
//
//  channel   handshake                     beat contents
//  item      item_valid / item_ready       mode, tick, level
//  result    result_valid / result_ready   event_kind, pressed
//  config    APB psel/penable/pwrite       paddr, pwdata, prdata
//
// one beat a cycle while the result is not stalled: an item sits in the input
// register, where the state update and classification run, then the result lands
// in the output register
// reset clears the state to released/idle and loads the default durations
// a stalled result keeps the next item in the input register and drops item_ready

module button_debounce_duration_classifier
	import bddc_pkg::*;
#(
	parameter int TICK_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic                 mode,
	input  logic [31:0]          tick,
	input  logic                 level,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [1:0]           event_kind,
	output logic                 pressed,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready
);

	typedef logic [TICK_BITS-1:0] tick_t;

	// configuration
	logic [DUR_BITS-1:0] debounce_q, long_q, xlong_q;
	logic                active_level_q;
	reg_index_t          reg_idx;
	logic                cfg_wr;

	// input stage
	logic  s1_valid_q;
	logic  mode_s1, level_s1;
	tick_t tick_s1;

	// classifier state
	phase_t phase_q;
	logic   stable_q, cand_act_q, xl_done_q, rel_sup_q;
	tick_t  cand_time_q, press_time_q;

	// output register
	logic        out_valid_q;
	event_kind_t kind_q;
	logic        pressed_q;

	// next state
	phase_t      ph;
	logic        stp, ca, xd, rs, ev_v, stop, act;
	tick_t       ct, pt, now, dur;
	event_kind_t ev_k;
	logic        adv;

	function automatic logic is_due(input tick_t diff, input logic [DUR_BITS-1:0] lim);
		return 32'(diff) >= 32'(lim);
	endfunction

	assign pready  = 1'b1;
	assign reg_idx = reg_index_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_idx)
			REG_DEBOUNCE:   prdata = {1'b0, debounce_q};
			REG_LONG:       prdata = {1'b0, long_q};
			REG_EXTRA_LONG: prdata = {1'b0, xlong_q};
			REG_ACTIVE_LVL: prdata = {31'd0, active_level_q};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= DEBOUNCE_RST;
			long_q         <= LONG_RST;
			xlong_q        <= EXTRA_LONG_RST;
			active_level_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_DEBOUNCE:   debounce_q     <= pwdata[DUR_BITS-1:0];
				REG_LONG:       long_q         <= pwdata[DUR_BITS-1:0];
				REG_EXTRA_LONG: xlong_q        <= pwdata[DUR_BITS-1:0];
				REG_ACTIVE_LVL: active_level_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign adv          = s1_valid_q && (!out_valid_q || result_ready);
	assign item_ready   = !s1_valid_q || adv;
	assign result_valid = out_valid_q;
	assign event_kind   = kind_q;
	assign pressed      = pressed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_valid && item_ready) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			mode_s1  <= mode;
			tick_s1  <= tick[TICK_BITS-1:0];
			level_s1 <= level;
		end
	end

	always_comb begin
		ph   = phase_q;
		stp  = stable_q;
		ca   = cand_act_q;
		ct   = cand_time_q;
		pt   = press_time_q;
		xd   = xl_done_q;
		rs   = rel_sup_q;
		ev_v = 1'b0;
		ev_k = EV_SHORT;
		stop = 1'b0;
		dur  = '0;
		now  = tick_s1;
		act  = (level_s1 == active_level_q);

		// finish a due debounce deadline
		if (ph == PH_DEB) begin
			if (!is_due(now - ct, debounce_q)) begin
				stop = 1'b1;
			end else if (mode_s1 && act != ca) begin
				ca   = act;
				ct   = now;
				stop = 1'b1;
			end else begin
				ph = ca ? PH_HELD : PH_IDLE;
				if (ca != stp) begin
					stp = ca;
					if (ca) begin
						pt = ct;
						xd = 1'b0;
						rs = 1'b0;
					end else if (rs || xd) begin
						rs   = 1'b0;
						xd   = 1'b0;
						stop = 1'b1;
					end else begin
						dur  = ct - pt;
						ev_v = 1'b1;
						stop = 1'b1;
						priority if (is_due(dur, xlong_q)) begin
							ev_k = EV_XLONG;
						end else if (is_due(dur, long_q)) begin
							ev_k = EV_LONG;
						end else begin
							ev_k = EV_SHORT;
						end
					end
				end
			end
		end

		// extra-long deadline while held
		if (!stop && ph == PH_HELD && !rs && !xd && is_due(now - pt, xlong_q)) begin
			if (mode_s1 && !act) begin
				ph = PH_DEB;
				ca = 1'b0;
				ct = now;
				rs = 1'b1;
			end else begin
				xd   = 1'b1;
				ev_v = 1'b1;
				ev_k = EV_XLONG;
			end
		end

		// edge restarts debounce
		if (!mode_s1) begin
			ct = now;
			ca = act;
			ph = PH_DEB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			stable_q     <= 1'b0;
			cand_act_q   <= 1'b0;
			cand_time_q  <= '0;
			press_time_q <= '0;
			xl_done_q    <= 1'b0;
			rel_sup_q    <= 1'b0;
		end else if (adv) begin
			phase_q      <= ph;
			stable_q     <= stp;
			cand_act_q   <= ca;
			cand_time_q  <= ct;
			press_time_q <= pt;
			xl_done_q    <= xd;
			rel_sup_q    <= rs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ev_v;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ev_v) begin
			kind_q    <= ev_k;
			pressed_q <= stp;
		end
	end

endmodule

@@ hw/rtl/bddc_checker.sv @@
// bddc_checker: port-level checks for the button debounce duration classifier
// depends on bddc_pkg; bound to button_debounce_duration_classifier

module bddc_checker
	import bddc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic [1:0] event_kind,
	input logic       pressed,
	input logic       pready
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(event_kind) && $stable(pressed))
		else $error("result beat changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> event_kind == EV_SHORT || event_kind == EV_LONG
			|| event_kind == EV_XLONG)
		else $error("bad event kind");

	// short and long come only from a release
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (event_kind == EV_SHORT || event_kind == EV_LONG) |-> !pressed)
		else $error("short or long press reported while pressed");

	// a result while still pressed can only be extra long
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pressed |-> event_kind == EV_XLONG)
		else $error("held result is not extra long");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind button_debounce_duration_classifier bddc_checker u_bddc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.event_kind   (event_kind),
	.pressed      (pressed),
	.pready       (pready)
);

@@ tb/sv/tb_button_debounce_duration_classifier.sv @@
// tb_button_debounce_duration_classifier: self-checking testbench for the debounce duration classifier
// drives press sessions and noise on the item port, predicts press events, checks the result port
// depends on bddc_pkg and button_debounce_duration_classifier

`timescale 1ns / 100ps

module tb_button_debounce_duration_classifier;
	import bddc_pkg::*;

	localparam bit MODE_EDGE = 1'b0;
	localparam bit MODE_POLL = 1'b1;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		logic        mode;
		logic [31:0] tick;
		logic        level;
	} button_item_t;

	typedef struct {
		event_kind_t kind;
		logic        pressed;
	} press_event_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	logic                 mode = 1'b0;
	logic [31:0]          tick = '0;
	logic                 level = 1'b0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [1:0]           event_kind;
	logic                 pressed;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	button_debounce_duration_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode(mode),
		.tick(tick),
		.level(level),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.event_kind(event_kind),
		.pressed(pressed),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// configuration shadow
	logic [DUR_BITS-1:0] cfg_deb = DEBOUNCE_RST;
	logic [DUR_BITS-1:0] cfg_long = LONG_RST;
	logic [DUR_BITS-1:0] cfg_xl = EXTRA_LONG_RST;
	logic                cfg_act = 1'b0;

	// predicted classifier state
	phase_t      ph = PH_IDLE;
	logic        stab_pressed = 1'b0;
	logic        cand_pressed = 1'b0;
	logic [31:0] cand_tick = '0;
	logic [31:0] press_start = '0;
	logic        xlong_done = 1'b0;
	logic        release_muted = 1'b0;

	button_item_t pending[$];
	press_event_t expected_events[$];
	int unsigned  queued_count = 0;
	int unsigned  accepted_count = 0;
	int unsigned  errors = 0;
	logic [31:0]  now_t = '0;
	bit           no_idle = 1'b0;
	bit           hold_off_req = 1'b0;
	int unsigned  send_wait = 0;
	int unsigned  result_stall = 0;
	button_item_t next_item;
	press_event_t want;

	function automatic bit reached(logic [31:0] now, logic [31:0] start, logic [DUR_BITS-1:0] dur);
		logic [31:0] diff;
		diff = now - start;
		return diff >= {1'b0, dur};
	endfunction

	function automatic bit settle_deadlines(input logic [31:0] now, input logic poll,
			input logic act_now, output event_kind_t kind);
		logic [31:0] span;
		kind = EV_SHORT;
		if (ph == PH_DEB) begin
			if (!reached(now, cand_tick, cfg_deb))
				return 1'b0;
			if (poll && act_now != cand_pressed) begin
				cand_pressed = act_now;
				cand_tick = now;
				return 1'b0;
			end
			ph = cand_pressed ? PH_HELD : PH_IDLE;
			if (cand_pressed != stab_pressed) begin
				stab_pressed = cand_pressed;
				if (cand_pressed) begin
					press_start = cand_tick;
					xlong_done = 1'b0;
					release_muted = 1'b0;
				end else begin
					if (release_muted || xlong_done) begin
						release_muted = 1'b0;
						xlong_done = 1'b0;
						return 1'b0;
					end
					span = cand_tick - press_start;
					if (span >= {1'b0, cfg_xl})
						kind = EV_XLONG;
					else if (span >= {1'b0, cfg_long})
						kind = EV_LONG;
					else
						kind = EV_SHORT;
					return 1'b1;
				end
			end
		end
		if (ph == PH_HELD && !release_muted && !xlong_done &&
				reached(now, press_start, cfg_xl)) begin
			// let go right at the extra-long deadline
			if (poll && !act_now) begin
				ph = PH_DEB;
				cand_pressed = 1'b0;
				cand_tick = now;
				release_muted = 1'b1;
				return 1'b0;
			end
			xlong_done = 1'b1;
			kind = EV_XLONG;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic classify_item(logic m, logic [31:0] t, logic lv);
		event_kind_t kind;
		bit found;
		logic act;
		act = (lv == cfg_act);
		found = settle_deadlines(t, m == MODE_POLL, act, kind);
		if (m == MODE_EDGE) begin
			cand_tick = t;
			cand_pressed = act;
			ph = PH_DEB;
		end
		if (found)
			expected_events.push_back('{kind, stab_pressed});
	endtask

	function automatic int unsigned idle_len();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// item driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) begin
				classify_item(mode, tick, level);
				accepted_count++;
			end
			if (!item_valid || item_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					item_valid <= 1'b0;
				end else if (pending.size() != 0) begin
					next_item = pending.pop_front();
					mode <= next_item.mode;
					tick <= next_item.tick;
					level <= next_item.level;
					item_valid <= 1'b1;
					send_wait = idle_len();
				end else
					item_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected result beat: event_kind %0d pressed %0b", event_kind, pressed);
					errors++;
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind) begin
						$error("event_kind expected %0d actual %0d", want.kind, event_kind);
						errors++;
					end
					if (pressed !== want.pressed) begin
						$error("pressed expected %0b actual %0b", want.pressed, pressed);
						errors++;
					end
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_stall = HOLD_OFF_CYCLES;
			end else if (result_stall == 0)
				result_stall = idle_len();
			if (result_stall > 0) begin
				result_stall--;
				result_ready <= 1'b0;
			end else
				result_ready <= 1'b1;
		end
	end

	task automatic reg_write(reg_index_t idx, logic [DATA_BITS-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DEBOUNCE:   cfg_deb = val[DUR_BITS-1:0];
			REG_LONG:       cfg_long = val[DUR_BITS-1:0];
			REG_EXTRA_LONG: cfg_xl = val[DUR_BITS-1:0];
			REG_ACTIVE_LVL: cfg_act = val[0];
			default:        ;
		endcase
	endtask

	task automatic set_config(logic [DUR_BITS-1:0] deb, logic [DUR_BITS-1:0] lng,
			logic [DUR_BITS-1:0] xl, logic act);
		reg_write(REG_DEBOUNCE, {1'b0, deb});
		reg_write(REG_LONG, {1'b0, lng});
		reg_write(REG_EXTRA_LONG, {1'b0, xl});
		reg_write(REG_ACTIVE_LVL, {31'b0, act});
	endtask

	task automatic add_item(bit m, logic [31:0] t, bit lv);
		pending.push_back('{m, t, lv});
		queued_count++;
	endtask

	function automatic logic [31:0] bounce_gap();
		if (cfg_deb == 0)
			return $urandom_range(0, 1);
		return $urandom_range(0, cfg_deb - 1);
	endfunction

	function automatic logic [31:0] pick_span();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, cfg_long);
			1: return {1'b0, cfg_long} +
				$urandom_range(0, cfg_xl > cfg_long ? cfg_xl - cfg_long : 10);
			2: return {1'b0, cfg_xl} + $urandom_range(0, 40);
			3: return {1'b0, cfg_long} - 1;
			4: return {1'b0, cfg_xl} - 1;
			default: return {1'b0, cfg_deb} + $urandom_range(0, 3);
		endcase
	endfunction

	task automatic add_press_session();
		logic [31:0] press_at;
		logic [31:0] span;
		logic [31:0] t;
		bit pl;
		pl = cfg_act;
		repeat ($urandom_range(0, 2)) begin
			add_item(MODE_EDGE, now_t, pl);
			now_t += bounce_gap();
			add_item(MODE_EDGE, now_t, !pl);
			now_t += bounce_gap();
		end
		add_item(MODE_EDGE, now_t, pl);
		press_at = now_t;
		span = pick_span();
		if ($urandom_range(0, 3) == 0) begin
			add_item(MODE_POLL, press_at + cfg_deb, pl);
			t = press_at + cfg_xl;
			add_item(MODE_POLL, t, !pl);
			add_item(MODE_POLL, t + cfg_deb, !pl);
		end else begin
			t = press_at;
			repeat ($urandom_range(0, 3)) begin
				t += $urandom_range(0, span / 4);
				add_item(MODE_POLL, t, pl);
			end
			if (span >= {1'b0, cfg_xl} && $urandom_range(0, 1))
				add_item(MODE_POLL, press_at + cfg_xl, pl);
			t = press_at + span;
			repeat ($urandom_range(0, 2)) begin
				add_item(MODE_EDGE, t, !pl);
				t += bounce_gap();
				add_item(MODE_EDGE, t, pl);
				t += bounce_gap();
			end
			add_item(MODE_EDGE, t, !pl);
			if ($urandom_range(0, 1))
				add_item(MODE_POLL, t + cfg_deb + $urandom_range(0, 2), !pl);
		end
		now_t = t + cfg_deb + $urandom_range(1, 30);
	endtask

	task automatic fill_random(int unsigned n);
		int unsigned target;
		target = queued_count + n;
		now_t = $urandom;
		while (queued_count < target) begin
			if ($urandom_range(0, 99) < 15) begin
				if ($urandom_range(0, 1))
					add_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
				else
					add_item(1'($urandom_range(0, 1)), now_t + $urandom_range(0, 50),
						1'($urandom_range(0, 1)));
			end else
				add_press_session();
		end
	endtask

	task automatic drain();
		int guard;
		while (accepted_count != queued_count)
			@(posedge clk);
		guard = 0;
		while (expected_events.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (expected_events.size() != 0) begin
			$error("%0d expected events never arrived", expected_events.size());
			errors++;
			expected_events.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [DUR_BITS-1:0] d;
		logic [DUR_BITS-1:0] l;
		logic [DUR_BITS-1:0] x;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_config(DEBOUNCE_RST, LONG_RST, EXTRA_LONG_RST, 1'b0);

		// debounce restart on a changed level at the deadline
		add_item(MODE_EDGE, 32'd100, 1'b0);
		add_item(MODE_POLL, 32'd110, 1'b0);
		add_item(MODE_POLL, 32'd120, 1'b1);
		add_item(MODE_POLL, 32'd140, 1'b1);
		// held through extra-long, then a silent release
		add_item(MODE_EDGE, 32'd200, 1'b0);
		add_item(MODE_POLL, 32'd220, 1'b0);
		add_item(MODE_POLL, 32'd3200, 1'b0);
		add_item(MODE_EDGE, 32'd3300, 1'b1);
		add_item(MODE_POLL, 32'd3320, 1'b1);
		// short press finished by the next edge
		add_item(MODE_EDGE, 32'd4000, 1'b0);
		add_item(MODE_EDGE, 32'd4020, 1'b1);
		add_item(MODE_EDGE, 32'd5100, 1'b0);
		// long press
		add_item(MODE_POLL, 32'd5120, 1'b0);
		add_item(MODE_EDGE, 32'd6200, 1'b1);
		add_item(MODE_POLL, 32'd6220, 1'b1);
		// release seen exactly at the extra-long deadline
		add_item(MODE_EDGE, 32'd7000, 1'b0);
		add_item(MODE_POLL, 32'd7020, 1'b0);
		add_item(MODE_POLL, 32'd10000, 1'b1);
		add_item(MODE_POLL, 32'd10020, 1'b1);
		// tick wrap
		add_item(MODE_EDGE, 32'hFFFF_FFF0, 1'b0);
		add_item(MODE_POLL, 32'hFFFF_FFFF, 1'b0);
		add_item(MODE_POLL, 32'h0000_0004, 1'b0);
		add_item(MODE_EDGE, 32'h0000_0200, 1'b1);
		add_item(MODE_POLL, 32'h0000_0214, 1'b1);
		add_item(MODE_EDGE, 32'h0000_0000, 1'b1);
		add_item(MODE_POLL, 32'h0000_0014, 1'b1);
		fill_random(180);
		drain();

		set_config('0, '0, '0, 1'b1);
		fill_random(200);
		drain();

		set_config('1, '1, '1, 1'b0);
		fill_random(120);
		drain();

		// receiver holds off while the sender streams without gaps
		set_config(31'd5, 31'd40, 31'd100, 1'b1);
		no_idle = 1'b1;
		fill_random(150);
		hold_off_req = 1'b1;
		drain();
		no_idle = 1'b0;

		repeat (3) begin
			d = 31'($urandom_range(0, 30));
			l = 31'($urandom_range(0, 400));
			x = 31'($urandom_range(0, 800));
			set_config(d, l, x, 1'($urandom_range(0, 1)));
			fill_random(200);
			drain();
		end

		set_config(31'd3, 31'd200, 31'd60, 1'b0);
		fill_random(200);
		drain();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
